FILE: rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Types and codes shared by the pulsed relay controller modules.
// ----------------------------------------------------------------------------
package prc_pkg;

    // Fixed widths of the transfer fields
    localparam int DATA_W     = 32;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_OPEN  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Relay status codes
    localparam logic [1:0] ST_CLOSED  = 2'd0;
    localparam logic [1:0] ST_OPEN    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
    localparam logic [1:0] ERR_REJECTED = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MODE_FLAGS   = 3'd0;
    localparam logic [2:0] REG_OUTPUT_FIELD = 3'd1;
    localparam logic [2:0] REG_INPUT_FIELD  = 3'd2;
    localparam logic [2:0] REG_CLOSE_VALUES = 3'd3;
    localparam logic [2:0] REG_OPEN_VALUES  = 3'd4;
    localparam logic [2:0] REG_EXPECTED     = 3'd5;
    localparam logic [2:0] REG_TIMING       = 3'd6;

    // Mode flag bit positions
    localparam int MF_INV_OUT     = 0;
    localparam int MF_INV_IN      = 1;
    localparam int MF_IGNORE      = 2;
    localparam int MF_CLOSED_ONLY = 3;
    localparam int MF_OPEN_ONLY   = 4;
    localparam int MF_SUPPRESS    = 5;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PULSE  = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] port_word;
    } in_item_t;

    typedef struct packed {
        logic              write_valid;
        logic [DATA_W-1:0] write_word;
        logic              status_valid;
        logic [1:0]        position;
        logic              done_res;
        logic [1:0]        error_code;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  mode_flags;
        logic [13:0] output_field;
        logic [13:0] input_field;
        logic [63:0] close_values;
        logic [63:0] open_values;
        logic [63:0] expected_inputs;
        logic [63:0] timing;
    } cfg_t;

    // Field unit answers to the sequencer
    typedef struct packed {
        logic [DATA_W-1:0] start_word;
        logic [DATA_W-1:0] finish_word;
        logic [1:0]        status;
        logic [1:0]        status_err;
    } field_res_t;

endpackage

FILE: rtl/core/prc_cfg_regs.sv
// ----------------------------------------------------------------------------
// prc_cfg_regs
// APB register file holding the relay controller configuration.
// ----------------------------------------------------------------------------
module prc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [prc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [prc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output prc_pkg::cfg_t                       cfg
);

    prc_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                prc_pkg::REG_MODE_FLAGS:   cfg_reg.mode_flags      <= pwdata[5:0];
                prc_pkg::REG_OUTPUT_FIELD: cfg_reg.output_field    <= pwdata[13:0];
                prc_pkg::REG_INPUT_FIELD:  cfg_reg.input_field     <= pwdata[13:0];
                prc_pkg::REG_CLOSE_VALUES: cfg_reg.close_values    <= pwdata;
                prc_pkg::REG_OPEN_VALUES:  cfg_reg.open_values     <= pwdata;
                prc_pkg::REG_EXPECTED:     cfg_reg.expected_inputs <= pwdata;
                prc_pkg::REG_TIMING:       cfg_reg.timing          <= pwdata;
                default:                   ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_index)
            prc_pkg::REG_MODE_FLAGS:   prdata = {58'd0, cfg_reg.mode_flags};
            prc_pkg::REG_OUTPUT_FIELD: prdata = {50'd0, cfg_reg.output_field};
            prc_pkg::REG_INPUT_FIELD:  prdata = {50'd0, cfg_reg.input_field};
            prc_pkg::REG_CLOSE_VALUES: prdata = cfg_reg.close_values;
            prc_pkg::REG_OPEN_VALUES:  prdata = cfg_reg.open_values;
            prc_pkg::REG_EXPECTED:     prdata = cfg_reg.expected_inputs;
            prc_pkg::REG_TIMING:       prdata = cfg_reg.timing;
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/prc_field_unit.sv
// ----------------------------------------------------------------------------
// prc_field_unit
// Output field insert and input field classification for one item.
// ----------------------------------------------------------------------------
module prc_field_unit #(
    parameter int WORD_WIDTH = 32
) (
    input  prc_pkg::cfg_t                  cfg,
    input  logic                           is_close,
    input  logic [prc_pkg::DATA_W-1:0]     port_word,
    input  logic [1:0]                     last_command,
    output prc_pkg::field_res_t            res
);

    localparam logic [prc_pkg::DATA_W-1:0] WORD_MASK =
        {prc_pkg::DATA_W{1'b1}} >> (prc_pkg::DATA_W - WORD_WIDTH);
    localparam logic [5:0] WW6 = 6'(WORD_WIDTH);

    // Ones of the given field width, saturated at the word width
    function automatic logic [prc_pkg::DATA_W-1:0] field_ones(input logic [5:0] w);
        logic [5:0] ws;
        ws = (w > WW6) ? WW6 : w;
        return ~({prc_pkg::DATA_W{1'b1}} << ws);
    endfunction

    logic [5:0]                 out_off;
    logic [5:0]                 in_off;
    logic [prc_pkg::DATA_W-1:0] out_mask;
    logic [prc_pkg::DATA_W-1:0] base_word;
    logic [63:0]                vals;
    logic [prc_pkg::DATA_W-1:0] pulse_v;
    logic [prc_pkg::DATA_W-1:0] idle_v;
    logic [prc_pkg::DATA_W-1:0] cur;
    logic                       hit_closed;
    logic                       hit_open;

    always_comb
    begin
        // Insert pulse and idle values into the output field
        out_off   = cfg.output_field[5:0];
        out_mask  = (field_ones(cfg.output_field[13:8]) << out_off) & WORD_MASK;
        vals      = is_close ? cfg.close_values : cfg.open_values;
        pulse_v   = vals[31:0];
        idle_v    = vals[63:32];
        if (cfg.mode_flags[prc_pkg::MF_INV_OUT])
        begin
            pulse_v = ~pulse_v;
            idle_v  = ~idle_v;
        end
        base_word       = port_word & WORD_MASK & ~out_mask;
        res.start_word  = base_word | ((pulse_v << out_off) & out_mask);
        res.finish_word = base_word | ((idle_v << out_off) & out_mask);

        // Extract the input field and classify the position
        in_off = cfg.input_field[5:0];
        cur    = port_word & WORD_MASK;
        if (cfg.mode_flags[prc_pkg::MF_INV_IN])
        begin
            cur = ~cur & WORD_MASK;
        end
        cur        = (cur >> in_off) & field_ones(cfg.input_field[13:8]);
        hit_closed = (cur == cfg.expected_inputs[31:0]);
        hit_open   = (cur == cfg.expected_inputs[63:32]);

        res.status_err = prc_pkg::ERR_NONE;
        if (cfg.mode_flags[prc_pkg::MF_IGNORE])
        begin
            res.status = last_command;
        end
        else if (cfg.mode_flags[prc_pkg::MF_CLOSED_ONLY])
        begin
            res.status = hit_closed ? prc_pkg::ST_CLOSED : prc_pkg::ST_OPEN;
        end
        else if (cfg.mode_flags[prc_pkg::MF_OPEN_ONLY])
        begin
            res.status = hit_open ? prc_pkg::ST_OPEN : prc_pkg::ST_CLOSED;
        end
        else if (hit_closed)
        begin
            res.status = prc_pkg::ST_CLOSED;
        end
        else if (hit_open)
        begin
            res.status = prc_pkg::ST_OPEN;
        end
        else
        begin
            res.status = prc_pkg::ST_ILLEGAL;
            if (!cfg.mode_flags[prc_pkg::MF_SUPPRESS])
            begin
                res.status_err = prc_pkg::ERR_ILLEGAL;
            end
        end
    end

endmodule

FILE: rtl/core/prc_sequencer.sv
// ----------------------------------------------------------------------------
// prc_sequencer
// Pulse and settling sequencer with the result register.
// ----------------------------------------------------------------------------
module prc_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  kind,
    input  prc_pkg::field_res_t         fres,
    input  logic [63:0]                 timing,
    input  logic                        out_ready,
    output logic [1:0]                  last_command,
    output logic                        out_valid,
    output prc_pkg::out_item_t          out_data
);

    prc_pkg::phase_t             phase_reg, phase_next;
    logic [31:0]                 countdown_reg, countdown_next;
    logic [prc_pkg::DATA_W-1:0]  finish_reg, finish_next;
    logic [1:0]                  last_cmd_reg, last_cmd_next;
    logic                        out_valid_reg, out_valid_next;
    prc_pkg::out_item_t          out_data_reg;
    prc_pkg::out_item_t          res;
    logic                        res_valid;
    logic                        cnt_last;

    assign cnt_last     = (countdown_reg <= 32'd1);
    assign last_command = last_cmd_reg;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        finish_next    = finish_reg;
        last_cmd_next  = last_cmd_reg;
        if (accept)
        begin
            case (kind)
                prc_pkg::KIND_TICK:
                begin
                    case (phase_reg)
                        prc_pkg::PH_PULSE:
                        begin
                            if (cnt_last)
                            begin
                                phase_next     = prc_pkg::PH_SETTLE;
                                countdown_next = timing[63:32];
                            end
                            else
                            begin
                                countdown_next = countdown_reg - 32'd1;
                            end
                        end
                        prc_pkg::PH_SETTLE:
                        begin
                            if (cnt_last)
                            begin
                                phase_next     = prc_pkg::PH_IDLE;
                                countdown_next = '0;
                            end
                            else
                            begin
                                countdown_next = countdown_reg - 32'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                prc_pkg::KIND_CLOSE, prc_pkg::KIND_OPEN:
                begin
                    if (phase_reg == prc_pkg::PH_IDLE)
                    begin
                        phase_next     = prc_pkg::PH_PULSE;
                        countdown_next = timing[31:0];
                        finish_next    = fres.finish_word;
                        last_cmd_next  = (kind == prc_pkg::KIND_CLOSE) ?
                                         prc_pkg::ST_CLOSED : prc_pkg::ST_OPEN;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result for the item at the input
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        case (kind)
            prc_pkg::KIND_TICK:
            begin
                if (phase_reg == prc_pkg::PH_PULSE && cnt_last)
                begin
                    res_valid       = 1'b1;
                    res.write_valid = 1'b1;
                    res.write_word  = finish_reg;
                end
                else if (phase_reg == prc_pkg::PH_SETTLE && cnt_last)
                begin
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                end
            end
            prc_pkg::KIND_CLOSE, prc_pkg::KIND_OPEN:
            begin
                res_valid = 1'b1;
                if (phase_reg != prc_pkg::PH_IDLE)
                begin
                    res.error_code = prc_pkg::ERR_REJECTED;
                end
                else
                begin
                    res.write_valid = 1'b1;
                    res.write_word  = fres.start_word;
                end
            end
            default:
            begin
                res_valid        = 1'b1;
                res.status_valid = 1'b1;
                res.position     = fres.status;
                res.error_code   = fres.status_err;
            end
        endcase
    end

    // Hold a result until it is taken
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= prc_pkg::PH_IDLE;
            countdown_reg <= '0;
            finish_reg    <= '0;
            last_cmd_reg  <= prc_pkg::ST_ILLEGAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            finish_reg    <= finish_next;
            last_cmd_reg  <= last_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

FILE: rtl/core/pulsed_relay_controller_core.sv
// A result is registered: it is valid in the cycle after its item's input transfer.
// Throughput: one item per cycle; in_ready is high whenever the result
// register is empty or its result is taken in the same cycle.
// Ticks that end no phase, and ticks while idle, produce no result.
// Reset (rst_n low, asynchronous): idle phase, counters and registers zero,
// last command illegal, result register empty.
// ----------------------------------------------------------------------------
// pulsed_relay_controller_core
// Pulsed relay driver: field insert, pulse and settling timing, status query.
// ----------------------------------------------------------------------------
module pulsed_relay_controller_core #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  prc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output prc_pkg::out_item_t              out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [prc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [prc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    prc_pkg::cfg_t        cfg;
    prc_pkg::field_res_t  fres;
    logic [1:0]           last_command;
    logic                 accept;

    // Accept while the result register is free or draining
    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    prc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prc_field_unit #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_field_unit (
        .cfg          (cfg),
        .is_close     (in_data.kind == prc_pkg::KIND_CLOSE),
        .port_word    (in_data.port_word),
        .last_command (last_command),
        .res          (fres)
    );

    prc_sequencer u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (in_data.kind),
        .fres         (fres),
        .timing       (cfg.timing),
        .out_ready    (out_ready),
        .last_command (last_command),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );

endmodule
